@@ hw/rtl/tpa_pkg.sv @@
package tpa_pkg;

   localparam int unsigned IndexWidth = 32;

   localparam logic [1:0] MODE_LIST  = 2'd0;
   localparam logic [1:0] MODE_STRIP = 2'd1;
   localparam logic [1:0] MODE_FAN   = 2'd2;

   localparam logic CSR_PRIMITIVE_MODE = 1'b0;
   localparam logic CSR_VERTEX_COUNT   = 1'b1;

   typedef struct packed {
      logic [IndexWidth-1:0] corner_a;
      logic [IndexWidth-1:0] corner_b;
      logic [IndexWidth-1:0] corner_c;
      logic                  index_error;
   } result_type;

endpackage

@@ hw/rtl/tpa_core.sv @@
module tpa_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           advance,
   input  logic [tpa_pkg::IndexWidth-1:0] vertex_index,
   input  logic                           starts_primitive,
   input  logic [1:0]                     primitive_mode,
   input  logic [tpa_pkg::IndexWidth-1:0] vertex_count,
   output logic                           emit_valid,
   output tpa_pkg::result_type            emit_result
);
   import tpa_pkg::*;

   logic [1:0]            seen_count_ff, seen_count_in;
   logic [1:0]            list_phase_ff, list_phase_in;
   logic                  odd_position_ff, odd_position_in;
   logic                  halted_ff, halted_in;
   logic [IndexWidth-1:0] fan_center_ff, fan_center_in;
   logic [IndexWidth-1:0] older_index_ff, older_index_in;
   logic [IndexWidth-1:0] newer_index_ff, newer_index_in;

   always_comb begin
      seen_count_in   = starts_primitive ? 2'd0 : seen_count_ff;
      list_phase_in   = starts_primitive ? 2'd0 : list_phase_ff;
      odd_position_in = starts_primitive ? 1'b0 : odd_position_ff;
      halted_in       = starts_primitive ? 1'b0 : halted_ff;
      fan_center_in   = fan_center_ff;
      older_index_in  = older_index_ff;
      newer_index_in  = newer_index_ff;
      emit_valid      = 1'b0;
      emit_result     = '0;
      if (!halted_in) begin
         if (vertex_index >= vertex_count) begin
            halted_in               = 1'b1;
            emit_valid              = 1'b1;
            emit_result.index_error = 1'b1;
         end else begin
            case (primitive_mode)
               MODE_LIST: begin
                  case (list_phase_in)
                     2'd0: begin
                        older_index_in = vertex_index;
                        list_phase_in  = 2'd1;
                     end
                     2'd1: begin
                        newer_index_in = vertex_index;
                        list_phase_in  = 2'd2;
                     end
                     default: begin
                        emit_valid           = 1'b1;
                        emit_result.corner_a = older_index_ff;
                        emit_result.corner_b = newer_index_ff;
                        emit_result.corner_c = vertex_index;
                        list_phase_in        = 2'd0;
                     end
                  endcase
               end
               MODE_STRIP: begin
                  if (seen_count_in >= 2'd2) begin
                     emit_valid           = 1'b1;
                     emit_result.corner_a = odd_position_in ? newer_index_ff : older_index_ff;
                     emit_result.corner_b = odd_position_in ? older_index_ff : newer_index_ff;
                     emit_result.corner_c = vertex_index;
                  end else begin
                     seen_count_in = seen_count_in + 2'd1;
                  end
                  older_index_in  = newer_index_ff;
                  newer_index_in  = vertex_index;
                  odd_position_in = ~odd_position_in;
               end
               MODE_FAN: begin
                  case (seen_count_in)
                     2'd0: begin
                        fan_center_in = vertex_index;
                        seen_count_in = 2'd1;
                     end
                     2'd1: begin
                        newer_index_in = vertex_index;
                        seen_count_in  = 2'd2;
                     end
                     default: begin
                        emit_valid           = 1'b1;
                        emit_result.corner_a = fan_center_ff;
                        emit_result.corner_b = newer_index_ff;
                        emit_result.corner_c = vertex_index;
                        newer_index_in       = vertex_index;
                     end
                  endcase
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_count_ff   <= 2'd0;
         list_phase_ff   <= 2'd0;
         odd_position_ff <= 1'b0;
         halted_ff       <= 1'b0;
         fan_center_ff   <= '0;
         older_index_ff  <= '0;
         newer_index_ff  <= '0;
      end else if (advance) begin
         seen_count_ff   <= seen_count_in;
         list_phase_ff   <= list_phase_in;
         odd_position_ff <= odd_position_in;
         halted_ff       <= halted_in;
         fan_center_ff   <= fan_center_in;
         older_index_ff  <= older_index_in;
         newer_index_ff  <= newer_index_in;
      end
   end

endmodule

@@ hw/rtl/tpa_rsp_stage.sv @@
module tpa_rsp_stage (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           load,
   input  logic                           emit_valid,
   input  tpa_pkg::result_type            emit_result,
   output logic                           slot_free,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [tpa_pkg::IndexWidth-1:0] rsp_corner_a,
   output logic [tpa_pkg::IndexWidth-1:0] rsp_corner_b,
   output logic [tpa_pkg::IndexWidth-1:0] rsp_corner_c,
   output logic                           rsp_index_error
);
   import tpa_pkg::*;

   logic       valid_ff, valid_in;
   result_type result_ff;

   assign slot_free = !valid_ff || !rsp_stall;

   always_comb begin
      if (load) begin
         valid_in = emit_valid;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && emit_valid) begin
         result_ff <= emit_result;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_corner_a    = result_ff.corner_a;
   assign rsp_corner_b    = result_ff.corner_b;
   assign rsp_corner_c    = result_ff.corner_c;
   assign rsp_index_error = result_ff.index_error;

endmodule

@@ hw/rtl/triangle_primitive_assembly.sv @@
// Triangle primitive assembly: takes one vertex index per request, flagged at the start of
// each primitive, range-checks it against vertex_count and emits list, strip or fan order as
// separate triangles, or one error result for an out-of-range index, after which indices are
// ignored until the next start. A request is taken every cycle while the result side keeps
// up; each request passes an input register and the combinational assembly logic, and its
// triangle, if any, is then loaded into the result register, from which it can be taken.
// The result register alone decides back-pressure.
// Write primitive_mode and vertex_count only while idle.
module triangle_primitive_assembly (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [tpa_pkg::IndexWidth-1:0] req_vertex_index,
   input  logic                           req_starts_primitive,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [tpa_pkg::IndexWidth-1:0] rsp_corner_a,
   output logic [tpa_pkg::IndexWidth-1:0] rsp_corner_b,
   output logic [tpa_pkg::IndexWidth-1:0] rsp_corner_c,
   output logic                           rsp_index_error,
   input  logic                           csr_write_enable,
   input  logic                           csr_index,
   input  logic [tpa_pkg::IndexWidth-1:0] csr_write_data
);
   import tpa_pkg::*;

   logic [1:0]            primitive_mode_ff;
   logic [IndexWidth-1:0] vertex_count_ff;
   logic                  in_valid_ff, in_valid_in;
   logic [IndexWidth-1:0] in_index_ff;
   logic                  in_start_ff;
   logic                  slot_free;
   logic                  advance;
   logic                  req_take;
   logic                  emit_valid;
   result_type            emit_result;

   assign advance   = in_valid_ff && slot_free;
   assign req_stall = in_valid_ff && !slot_free;
   assign req_take  = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         primitive_mode_ff <= MODE_LIST;
         vertex_count_ff   <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_PRIMITIVE_MODE: primitive_mode_ff <= csr_write_data[1:0];
            CSR_VERTEX_COUNT:   vertex_count_ff   <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_index_ff <= req_vertex_index;
         in_start_ff <= req_starts_primitive;
      end
   end

   tpa_core u_core (
      .clock            (clock),
      .reset            (reset),
      .advance          (advance),
      .vertex_index     (in_index_ff),
      .starts_primitive (in_start_ff),
      .primitive_mode   (primitive_mode_ff),
      .vertex_count     (vertex_count_ff),
      .emit_valid       (emit_valid),
      .emit_result      (emit_result)
   );

   tpa_rsp_stage u_rsp_stage (
      .clock           (clock),
      .reset           (reset),
      .load            (advance),
      .emit_valid      (emit_valid),
      .emit_result     (emit_result),
      .slot_free       (slot_free),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_corner_a    (rsp_corner_a),
      .rsp_corner_b    (rsp_corner_b),
      .rsp_corner_c    (rsp_corner_c),
      .rsp_index_error (rsp_index_error)
   );

endmodule
